[design/pwmt_pkg.sv]
package pwmt_pkg;

  localparam int DATA_W       = 32;
  localparam int MAX_CHANNELS = 4;
  localparam int PRESCALE_W   = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // register map
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_CMP1   = 3'd2;
  localparam logic [2:0] REG_CMP2   = 3'd3;
  localparam logic [2:0] REG_CMP3   = 3'd4;
  localparam logic [2:0] REG_CMP4   = 3'd5;
  localparam logic [2:0] REG_STATUS = 3'd6;
  localparam logic [2:0] REG_FORCE  = 3'd7;

  // configuration port indexes
  localparam logic [1:0] CFG_PRESCALER   = 2'd0;
  localparam logic [1:0] CFG_AUTO_RELOAD = 2'd1;
  localparam logic [1:0] CFG_OUT_ENABLE  = 2'd2;
  localparam logic [1:0] CFG_POLARITY    = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [2:0]        reg_addr;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]       read_data;
    logic [MAX_CHANNELS-1:0] pwm_out;
    logic                    update_flag;
    logic [MAX_CHANNELS-1:0] compare_flags;
  } result_t;

endpackage

[design/pwm_timer_with_prescaler_core.sv]
// Prescaled up-counting timer, auto-reload, four compare channels in PWM mode 1.
// Input channel (in_valid/in_stall) carries one item per transfer: a tick, a
// register read or a register write (command, reg_addr, write_data).
// Output channel (out_valid/out_stall) returns exactly one result per item:
// read_data (zero unless a read), pwm_out, update_flag and compare_flags as
// they stand after that item.
// Configuration (cfg_we/cfg_index/cfg_data) sets prescaler, auto-reload,
// channel output enables and polarity; write it only while no item is in flight.
// An accepted item is latched in the input register, then executed as it
// moves into the result register, which drives the output port.
// Throughput: one item per cycle while the receiver does not stall; the timer
// update, compares and PWM levels are one pass of logic between the input
// register and the result register.
// A stalled receiver holds the result steady; the execute stage then stops
// and the input side stalls only once its register is also full.
// Reset (synchronous, active high) clears the counters, compares, status,
// both valid flags, and sets auto-reload to all ones.
module pwm_timer_with_prescaler_core import pwmt_pkg::*; #(
  parameter int NUM_CHANNELS  = 4,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              command,
  input  logic [2:0]              reg_addr,
  input  logic [DATA_W-1:0]       write_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DATA_W-1:0]       read_data,
  output logic [MAX_CHANNELS-1:0] pwm_out,
  output logic                    update_flag,
  output logic [MAX_CHANNELS-1:0] compare_flags,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [DATA_W-1:0]       cfg_data
);

  logic    item_valid;
  logic    advance;
  item_t   item;
  result_t res;
  result_t out_q;

  assign advance = item_valid && (!out_valid || !out_stall);

  pwmt_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .command    (command),
    .reg_addr   (reg_addr),
    .write_data (write_data),
    .advance    (advance),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  pwmt_exec #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign read_data     = out_q.read_data;
  assign pwm_out       = out_q.pwm_out;
  assign update_flag   = out_q.update_flag;
  assign compare_flags = out_q.compare_flags;

endmodule

[design/pwmt_in_reg.sv]
module pwmt_in_reg import pwmt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        command,
  input  logic [2:0]        reg_addr,
  input  logic [DATA_W-1:0] write_data,
  input  logic              advance,
  output logic              in_stall,
  output logic              item_valid,
  output item_t             item
);

  // hold while the execute stage cannot move its item on
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.command    <= command;
      item.reg_addr   <= reg_addr;
      item.write_data <= write_data;
    end
  end

endmodule

[design/pwmt_exec.sv]
module pwmt_exec import pwmt_pkg::*; #(
  parameter int NUM_CHANNELS  = 4,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  item_t             item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output result_t           res
);

  localparam int CW = COUNTER_WIDTH;
  localparam int NC = NUM_CHANNELS;

  // configuration
  logic [PRESCALE_W-1:0] prescaler;
  logic [CW-1:0]         auto_reload;
  logic [NC-1:0]         ch_enable;
  logic [NC-1:0]         polarity;

  // timer state
  logic [PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic [CW-1:0]         main_count, main_count_next;
  logic                  count_enable, count_enable_next;
  logic [CW-1:0]         compare_preload [NC];
  logic [CW-1:0]         compare_preload_next [NC];
  logic [CW-1:0]         compare_active [NC];
  logic [CW-1:0]         compare_active_next [NC];
  logic [NC:0]           status_bits, status_bits_next;

  logic [DATA_W-1:0] rd;
  logic [NC-1:0]     pwm;
  logic              load;
  logic              advanced;
  logic [NC-1:0]     force_set;
  cmd_t              cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler   <= '0;
      auto_reload <= '1;
      ch_enable   <= '0;
      polarity    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESCALER:   prescaler   <= cfg_data[PRESCALE_W-1:0];
        CFG_AUTO_RELOAD: auto_reload <= cfg_data[CW-1:0];
        CFG_OUT_ENABLE:  ch_enable   <= cfg_data[NC-1:0];
        CFG_POLARITY:    polarity    <= cfg_data[NC-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd                  = cmd_t'(item.command);
    prescale_count_next  = prescale_count;
    main_count_next      = main_count;
    count_enable_next    = count_enable;
    compare_preload_next = compare_preload;
    compare_active_next  = compare_active;
    status_bits_next     = status_bits;
    rd                   = '0;
    load                 = 1'b0;
    advanced             = 1'b0;
    force_set            = '0;

    case (cmd)
      CMD_TICK: begin
        if (count_enable) begin
          if (prescale_count >= prescaler) begin
            prescale_count_next = '0;
            advanced            = 1'b1;
            if (main_count == auto_reload || main_count == {CW{1'b1}}) begin
              main_count_next = '0;
              load            = 1'b1;
            end else begin
              main_count_next = main_count + CW'(1);
            end
          end else begin
            prescale_count_next = prescale_count + PRESCALE_W'(1);
          end
        end
      end
      CMD_READ: begin
        case (item.reg_addr)
          REG_CTRL:   rd = DATA_W'(count_enable);
          REG_COUNT:  rd = DATA_W'(main_count);
          REG_STATUS: rd = DATA_W'(status_bits);
          REG_CMP1, REG_CMP2, REG_CMP3, REG_CMP4: begin
            for (int i = 0; i < NC; i++) begin
              if (item.reg_addr == REG_CMP1 + 3'(i)) rd = DATA_W'(compare_preload[i]);
            end
          end
          default: rd = '0;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_addr)
          REG_CTRL:   count_enable_next = item.write_data[0];
          REG_COUNT:  main_count_next   = item.write_data[CW-1:0];
          REG_STATUS: status_bits_next  = status_bits & item.write_data[NC:0];
          REG_FORCE: begin
            if (item.write_data[0]) begin
              prescale_count_next = '0;
              main_count_next     = '0;
              load                = 1'b1;
            end
            force_set = item.write_data[NC:1];
          end
          REG_CMP1, REG_CMP2, REG_CMP3, REG_CMP4: begin
            for (int i = 0; i < NC; i++) begin
              if (item.reg_addr == REG_CMP1 + 3'(i)) begin
                compare_preload_next[i] = item.write_data[CW-1:0];
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // update event: preloads go live, update flag set
    if (load) begin
      compare_active_next = compare_preload;
      status_bits_next[0] = 1'b1;
    end
    status_bits_next[NC:1] = status_bits_next[NC:1] | force_set;

    if (advanced) begin
      for (int i = 0; i < NC; i++) begin
        if (main_count_next == compare_active_next[i]) status_bits_next[i+1] = 1'b1;
      end
    end

    // PWM mode 1 on the state after this item
    for (int i = 0; i < NC; i++) begin
      pwm[i] = ch_enable[i] & ((main_count_next < compare_active_next[i]) ^ polarity[i]);
    end

    res.read_data     = rd;
    res.pwm_out       = MAX_CHANNELS'(pwm);
    res.update_flag   = status_bits_next[0];
    res.compare_flags = MAX_CHANNELS'(status_bits_next[NC:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      main_count     <= '0;
      count_enable   <= 1'b0;
      status_bits    <= '0;
      for (int i = 0; i < NC; i++) begin
        compare_preload[i] <= '0;
        compare_active[i]  <= '0;
      end
    end else if (advance) begin
      prescale_count  <= prescale_count_next;
      main_count      <= main_count_next;
      count_enable    <= count_enable_next;
      status_bits     <= status_bits_next;
      compare_preload <= compare_preload_next;
      compare_active  <= compare_active_next;
    end
  end

endmodule

[design/pwmt_checker.sv]
module pwmt_checker import pwmt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [DATA_W-1:0]       read_data,
  input logic [MAX_CHANNELS-1:0] pwm_out,
  input logic                    update_flag,
  input logic [MAX_CHANNELS-1:0] compare_flags
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(pwm_out)
      && $stable(update_flag) && $stable(compare_flags))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // empty output side never back-pressures the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // accepted item reaches the output once the output side frees up
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted item did not produce a result");

endmodule

bind pwm_timer_with_prescaler_core pwmt_checker u_pwmt_checker (.*);
